// ----- rtl/rbm_conditional_probability_macros.svh -----
// Assertion macros for the RBM conditional-probability block.
// Included by files that carry concurrent assertions; needs i_clk and i_rst_n in scope.
`ifndef RBM_CONDITIONAL_PROBABILITY_MACROS_SVH
`define RBM_CONDITIONAL_PROBABILITY_MACROS_SVH

`ifndef SYNTHESIS
// Condition that must hold at every clock edge outside reset.
`define RBMCP_ASSERT_COMB(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);
// Condition that must hold in the cycle after the trigger.
`define RBMCP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RBMCP_ASSERT_COMB(lbl, cond, msg)
`define RBMCP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- rtl/rbmcp_pkg.sv -----
// Shared types, sizes and the sigmoid lookup table for the RBM conditional-probability block.
// No dependencies; used by the channel interfaces and the top level.
package rbmcp_pkg;

    // Layer sizes.
    localparam int NUM_VISIBLE = 64;
    localparam int NUM_HIDDEN  = 64;
    localparam int NUM_MAX     = (NUM_VISIBLE > NUM_HIDDEN) ? NUM_VISIBLE : NUM_HIDDEN;

    // Field widths of the transfer payloads.
    localparam int CMD_W  = 3;
    localparam int IDX_W  = 6;
    localparam int COEF_W = 16;
    localparam int PROB_W = 16;
    localparam int ACT_W  = 24;

    // Address and counter widths derived from the layer sizes.
    localparam int VIS_AW     = (NUM_VISIBLE > 1) ? $clog2(NUM_VISIBLE) : 1;
    localparam int HID_AW     = (NUM_HIDDEN > 1) ? $clog2(NUM_HIDDEN) : 1;
    localparam int CNT_W      = (NUM_MAX > 1) ? $clog2(NUM_MAX) : 1;
    localparam int WT_DEPTH   = NUM_VISIBLE * NUM_HIDDEN;
    localparam int WT_AW      = (WT_DEPTH > 1) ? $clog2(WT_DEPTH) : 1;
    localparam int BIAS_DEPTH = NUM_VISIBLE + NUM_HIDDEN;
    localparam int BIAS_AW    = $clog2(BIAS_DEPTH);

    // Accumulator holds one bias plus up to NUM_MAX weights without overflow.
    localparam int ACC_W = COEF_W + $clog2(NUM_MAX + 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_WEIGHT     = 3'd0,
        CMD_VIS_BIAS   = 3'd1,
        CMD_HID_BIAS   = 3'd2,
        CMD_SET_VIS    = 3'd3,
        CMD_SET_HID    = 3'd4,
        CMD_QUERY_HID  = 3'd5,
        CMD_QUERY_VIS  = 3'd6
    } t_cmd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_DRAIN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [CMD_W-1:0]         command;
        logic [IDX_W-1:0]         vis_index;
        logic [IDX_W-1:0]         hid_index;
        logic signed [COEF_W-1:0] coefficient;
        logic                     unit_value;
    } t_in_item;

    typedef struct packed {
        logic [PROB_W-1:0]       probability;
        logic signed [ACT_W-1:0] activation;
        logic                    answer_valid;
    } t_out_item;

    // Decoded controls of one input item.
    typedef struct packed {
        logic wt_we;
        logic bias_we;
        logic bias_hid;
        logic vis_set;
        logic hid_set;
        logic is_query;
        logic query_hid;
    } t_decode;

    // Sigmoid table: 256 entries at 1/16 steps over [-8, 8).
    typedef logic [255:0][PROB_W-1:0] t_sig_table;

    localparam logic [63:0] EXP_STEP_Q24 = 64'd17859253;
    localparam logic [63:0] ONE_Q24      = 64'd16777216;

    // Shift-subtract quotient; used only while building the constant table.
    function automatic logic [63:0] f_udiv(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // e^(m/16) in Q24, each step rounded half up.
    function automatic logic [63:0] f_exp_q24(input int m);
        logic [63:0] e;
        e = ONE_Q24;
        for (int n = 0; n < m; n++) begin
            e = (e * EXP_STEP_Q24 + (ONE_Q24 >> 1)) >> 24;
        end
        return e;
    endfunction

    function automatic t_sig_table f_sig_table();
        t_sig_table  tab;
        logic [63:0] e;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] p;
        for (int k = 0; k < 256; k++) begin
            if (k >= 128) begin
                e   = f_exp_q24(k - 128);
                num = e << 16;
            end else begin
                e   = f_exp_q24(128 - k);
                num = ONE_Q24 << 16;
            end
            den    = e + ONE_Q24;
            p      = f_udiv(num + (den >> 1), den);
            tab[k] = (p > 64'd65535) ? 16'hFFFF : p[PROB_W-1:0];
        end
        return tab;
    endfunction

    localparam t_sig_table SIG_TABLE = f_sig_table();

endpackage

// ----- rtl/rbmcp_if.sv -----
// Valid/ready channel interfaces for the input items and the result items.
// Depends on rbmcp_pkg for the payload structs.
interface rbm_in_if;
    import rbmcp_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item item;

    modport source(output valid, output item, input ready);
    modport sink(input valid, input item, output ready);
endinterface

interface rbm_out_if;
    import rbmcp_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item item;

    modport source(output valid, output item, input ready);
    modport sink(input valid, input item, output ready);
endinterface

// ----- rtl/rbm_conditional_probability.sv -----
// Binary RBM kernel: weight and bias memories, unit registers and the query sequencer.
// Depends on rbmcp_pkg, the channel interfaces in rbmcp_if.sv and the assertion macros.
//
// Usage. Items arrive on i_in as valid/ready transfers; every accepted item gives exactly
// one result transfer on o_out. Weight and bias writes and unit sets update the state and
// return an all-zero result with answer_valid low, registered in the cycle after acceptance. A query
// reads the bias, then sweeps the opposite layer through the weight RAM one weight per
// cycle, adding the weights of the active units. The clamped sum indexes the sigmoid
// table and the result (answer_valid high) is registered on o_out.
// A query with an index outside its layer skips the sweep and answers from the done
// state. The block takes one item at a time: a query holds off new items until its
// result is loaded, its sweep bound by the single read port of the weight RAM. Writes
// and sets can follow every cycle while the receiver is ready.
// Reset clears the unit registers, the sequencer state and the output valid flag; the
// weight and bias memories hold nothing defined until written and are never cleared.
// When the receiver stalls, the finished result stays in the output register and the
// block takes no new item until that result has been transferred or is leaving.
`include "rbm_conditional_probability_macros.svh"

module rbm_conditional_probability (
    input logic       i_clk,
    input logic       i_rst_n,
    rbm_in_if.sink    i_in,
    rbm_out_if.source o_out
);
    import rbmcp_pkg::*;

    localparam int VIS_XW = (VIS_AW > IDX_W) ? VIS_AW : IDX_W;
    localparam int HID_XW = (HID_AW > IDX_W) ? HID_AW : IDX_W;
    localparam logic signed [ACC_W-1:0] ACC_HI = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] ACC_LO = ACC_W'(-32768);

    // Input side.
    t_in_item           in_item;
    t_cmd               cmd;
    t_decode            dec;
    logic               in_ready;
    logic               in_xfer;
    logic [VIS_XW-1:0]  vis_x;
    logic [HID_XW-1:0]  hid_x;
    logic [VIS_AW-1:0]  vis_a;
    logic [HID_AW-1:0]  hid_a;
    logic               vis_ok;
    logic               hid_ok;
    logic               query_ok;
    logic [WT_AW-1:0]   row_base;
    logic [WT_AW-1:0]   wt_waddr;
    logic [BIAS_AW-1:0] bias_addr;

    // Memories.
    logic signed [COEF_W-1:0] wt_mem [WT_DEPTH];
    logic signed [COEF_W-1:0] bias_mem [BIAS_DEPTH];
    logic signed [COEF_W-1:0] r_wt_rdata;
    logic signed [COEF_W-1:0] r_bias_rdata;

    // Sequencer and datapath registers.
    t_state                  r_state;
    t_state                  n_state;
    logic [NUM_VISIBLE-1:0]  r_vis_units;
    logic [NUM_HIDDEN-1:0]   r_hid_units;
    logic [WT_AW-1:0]        r_addr;
    logic [WT_AW-1:0]        r_stride;
    logic [CNT_W-1:0]        r_cnt;
    logic [CNT_W-1:0]        r_last_cnt;
    logic                    r_query_hid;
    logic                    r_query_ok;
    logic                    r_uval;
    logic                    r_add_d;
    logic signed [ACC_W-1:0] r_acc;
    logic                    unit_bit;
    logic                    out_load;

    // Result path.
    logic [15:0]             clamped;
    logic [7:0]              sig_idx;
    logic [PROB_W-1:0]       sig_val;
    logic [PROB_W-1:0]       prob;
    logic signed [ACT_W-1:0] act_sat;
    t_out_item               out_next;
    t_out_item               r_out_item;
    logic                    r_out_valid;

    assign in_item = i_in.item;
    assign cmd     = t_cmd'(in_item.command);
    assign in_xfer = i_in.valid && in_ready;

    // Index range checks and narrowing to the layer address widths.
    assign vis_x  = VIS_XW'(in_item.vis_index);
    assign hid_x  = HID_XW'(in_item.hid_index);
    assign vis_a  = vis_x[VIS_AW-1:0];
    assign hid_a  = hid_x[HID_AW-1:0];
    assign vis_ok = 32'(in_item.vis_index) < 32'(NUM_VISIBLE);
    assign hid_ok = 32'(in_item.hid_index) < 32'(NUM_HIDDEN);

    // Command decoder.
    always_comb begin
        dec = '0;
        unique case (cmd)
            CMD_WEIGHT: begin
                dec.wt_we = vis_ok && hid_ok;
            end
            CMD_VIS_BIAS: begin
                dec.bias_we = vis_ok;
            end
            CMD_HID_BIAS: begin
                dec.bias_we  = hid_ok;
                dec.bias_hid = 1'b1;
            end
            CMD_SET_VIS: begin
                dec.vis_set = vis_ok;
            end
            CMD_SET_HID: begin
                dec.hid_set = hid_ok;
            end
            CMD_QUERY_HID: begin
                dec.is_query  = 1'b1;
                dec.query_hid = 1'b1;
                dec.bias_hid  = 1'b1;
            end
            CMD_QUERY_VIS: begin
                dec.is_query = 1'b1;
            end
            default: begin
                dec = '0;
            end
        endcase
    end

    assign query_ok = dec.query_hid ? hid_ok : vis_ok;

    // Addresses: weights are stored row by row, one row per visible unit.
    assign row_base  = WT_AW'(WT_AW'(vis_a) * WT_AW'(NUM_HIDDEN));
    assign wt_waddr  = row_base + WT_AW'(hid_a);
    assign bias_addr = dec.bias_hid ? BIAS_AW'(NUM_VISIBLE) + BIAS_AW'(hid_a)
                                    : BIAS_AW'(vis_a);

    // Weight RAM: one write at acceptance, one registered read per cycle for the sweep.
    always_ff @(posedge i_clk) begin
        if (in_xfer && dec.wt_we) begin
            wt_mem[wt_waddr] <= in_item.coefficient;
        end
        r_wt_rdata <= wt_mem[r_addr];
    end

    // Bias RAM: visible biases first, hidden biases after them.
    always_ff @(posedge i_clk) begin
        if (in_xfer && dec.bias_we) begin
            bias_mem[bias_addr] <= in_item.coefficient;
        end
        r_bias_rdata <= bias_mem[bias_addr];
    end

    // Binary unit registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vis_units <= '0;
            r_hid_units <= '0;
        end else if (in_xfer) begin
            if (dec.vis_set) begin
                r_vis_units[vis_a] <= in_item.unit_value;
            end
            if (dec.hid_set) begin
                r_hid_units[hid_a] <= in_item.unit_value;
            end
        end
    end

    // Unit of the swept layer that matches the weight being read.
    assign unit_bit = r_query_hid ? r_vis_units[r_cnt[VIS_AW-1:0]]
                                  : r_hid_units[r_cnt[HID_AW-1:0]];

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state, input ready and result load.
    always_comb begin
        n_state  = r_state;
        in_ready = 1'b0;
        out_load = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                in_ready = !r_out_valid || o_out.ready;
                if (in_xfer) begin
                    if (dec.is_query) begin
                        n_state = query_ok ? S_SWEEP : S_DONE;
                    end else begin
                        out_load = 1'b1;
                    end
                end
            end
            S_SWEEP: begin
                if (r_cnt == r_last_cnt) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Query control captured at acceptance.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_query_ok <= 1'b0;
        end else if (in_xfer && dec.is_query) begin
            r_query_ok <= query_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_add_d <= 1'b0;
        end else begin
            r_add_d <= (r_state == S_SWEEP) && unit_bit;
        end
    end

    // Sweep address, counter and accumulator.
    always_ff @(posedge i_clk) begin
        if (in_xfer && dec.is_query) begin
            r_query_hid <= dec.query_hid;
            r_uval      <= in_item.unit_value;
            r_cnt       <= '0;
            if (dec.query_hid) begin
                r_addr     <= WT_AW'(hid_a);
                r_stride   <= WT_AW'(NUM_HIDDEN);
                r_last_cnt <= CNT_W'(NUM_VISIBLE - 1);
            end else begin
                r_addr     <= row_base;
                r_stride   <= WT_AW'(1);
                r_last_cnt <= CNT_W'(NUM_HIDDEN - 1);
            end
        end else if (r_state == S_SWEEP) begin
            r_addr <= r_addr + r_stride;
            r_cnt  <= r_cnt + CNT_W'(1);
        end
        // The bias comes in the first sweep cycle; weights add the cycle after their read.
        if (r_state == S_SWEEP && r_cnt == '0) begin
            r_acc <= ACC_W'(r_bias_rdata);
        end else if (r_add_d) begin
            r_acc <= r_acc + ACC_W'(r_wt_rdata);
        end
    end

    // Clamp to [-8, 8) in Q4.12 and look up the sigmoid at 1/16 steps.
    assign clamped = (r_acc > ACC_HI) ? 16'h7FFF :
                     (r_acc < ACC_LO) ? 16'h8000 : r_acc[15:0];
    assign sig_idx = {~clamped[15], clamped[14:8]};
    assign sig_val = SIG_TABLE[sig_idx];

    // Probability of value zero is one minus the table entry, saturated.
    always_comb begin
        if (r_uval) begin
            prob = sig_val;
        end else if (sig_val == '0) begin
            prob = '1;
        end else begin
            prob = ~sig_val + PROB_W'(1);
        end
    end

    // Saturate the activation to the output width.
    generate
        if (ACC_W <= ACT_W) begin : g_act_wide
            assign act_sat = ACT_W'(r_acc);
        end else begin : g_act_sat
            localparam logic signed [ACC_W-1:0] ACT_HI = ACC_W'(8388607);
            localparam logic signed [ACC_W-1:0] ACT_LO = ACC_W'(-8388608);
            assign act_sat = (r_acc > ACT_HI) ? 24'sh7FFFFF :
                             (r_acc < ACT_LO) ? 24'sh800000 : r_acc[ACT_W-1:0];
        end
    endgenerate

    // Result item: zero for writes and sets, the answer for queries.
    always_comb begin
        out_next = '0;
        if (r_state == S_DONE) begin
            out_next.answer_valid = 1'b1;
            if (r_query_ok) begin
                out_next.probability = prob;
                out_next.activation  = act_sat;
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_item <= out_next;
        end
    end

    assign i_in.ready  = in_ready;
    assign o_out.valid = r_out_valid;
    assign o_out.item  = r_out_item;

    // Checks on the sequencer.
    `RBMCP_ASSERT_COMB(a_cnt_in_range, (r_state != S_SWEEP) || (r_cnt <= r_last_cnt),
                       "sweep counter beyond layer")
    `RBMCP_ASSERT_COMB(a_add_in_sweep, !r_add_d || r_state == S_SWEEP || r_state == S_DRAIN,
                       "weight add outside sweep")
    `RBMCP_ASSERT_NEXT(a_query_starts, in_xfer && dec.is_query,
                       r_state == S_SWEEP || r_state == S_DONE, "query did not start")
    `RBMCP_ASSERT_NEXT(a_write_result, in_xfer && !dec.is_query,
                       r_out_valid && !r_out_item.answer_valid, "write result missing")

endmodule
